// ===== sv/cau_pkg.sv =====
package cau_pkg;

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_DIV = 3'd3,
        ACT_MAG = 3'd4,
        ACT_EQ  = 3'd5
    } action_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT      = 2'd2;

    // quotient and root bits, one per iteration stage
    localparam int ITER_COUNT = 33;
    // product, sum, magnitude, prep, iterations, output
    localparam int PIPE_DEPTH = ITER_COUNT + 5;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] res_re;
        logic signed [31:0] res_im;
        logic               is_equal;
        logic [1:0]         status;
    } out_item_t;

    // fields carried down the pipe; the truncation stage replaces the fixed results for a multiply
    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] fix_re;
        logic [31:0] fix_im;
        logic        fix_sat;
        logic        is_equal;
    } cmn_t;

    typedef struct packed {
        cmn_t               cmn;
        logic signed [63:0] p0;
        logic signed [63:0] p1;
        logic signed [63:0] p2;
        logic signed [63:0] p3;
        logic signed [63:0] p4;
        logic signed [63:0] p5;
    } prod_t;

    typedef struct packed {
        cmn_t               cmn;
        logic signed [64:0] sre;
        logic signed [64:0] sim;
        logic [63:0]        den;
    } sum_t;

    typedef struct packed {
        cmn_t        cmn;
        logic        neg_re;
        logic        neg_im;
        logic [63:0] mag_re;
        logic [63:0] mag_im;
        logic [63:0] den;
    } mag_t;

    typedef struct packed {
        cmn_t        cmn;
        logic        neg_re;
        logic        neg_im;
        logic        ovf_re;
        logic        ovf_im;
        logic        den_zero;
        logic [63:0] den;
        logic [63:0] r_re;
        logic [63:0] r_im;
        logic [32:0] n_re;
        logic [32:0] n_im;
        logic [32:0] q_re;
        logic [32:0] q_im;
        logic [65:0] sq_src;
        logic [32:0] sq_rem;
        logic [32:0] sq_root;
    } stage_t;

endpackage

// ===== sv/complex_arithmetic_unit_core.sv =====
// channel   | valid      | stall      | payload
// ----------+------------+------------+---------------------
// request   | req_valid  | req_stall  | req  (in_item_t)
// response  | rsp_valid  | rsp_stall  | rsp  (out_item_t)
//
// one item per cycle sustained while the response is not stalled; the 33 restoring
// division and square root steps take one register stage each, plus five stages
// for products, sums, magnitudes, divider set-up and output saturation.
// rst_n clears only the stage valid bits. each stage moves on when it is empty
// or the stage after it moves, so bubbles close up under a response stall.
module complex_arithmetic_unit_core
    import cau_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  in_item_t  req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output out_item_t rsp
);

    localparam int EFF_BITS = (WORD_BITS > 32) ? 32 : ((WORD_BITS < 2) ? 2 : WORD_BITS);
    localparam logic signed [64:0] SAT_MAX = (65'sd1 <<< (EFF_BITS - 1)) - 65'sd1;
    localparam logic signed [64:0] SAT_MIN = -SAT_MAX - 65'sd1;
    localparam logic [33:0]        MAG_MAX = SAT_MAX[33:0];

    // {saturated, value}
    function automatic logic [32:0] sat_signed(input logic signed [64:0] v);
        logic signed [64:0] c;
        logic               s;
        c = v;
        s = 1'b0;
        if (v > SAT_MAX)
        begin
            c = SAT_MAX;
            s = 1'b1;
        end
        else if (v < SAT_MIN)
        begin
            c = SAT_MIN;
            s = 1'b1;
        end
        return {s, c[31:0]};
    endfunction

    function automatic logic [32:0] sat_mag(input logic neg, input logic [33:0] mag,
                                            input logic force_sat);
        logic [33:0] lim;
        logic [33:0] m;
        logic        s;
        lim = neg ? (MAG_MAX + 34'd1) : MAG_MAX;
        m   = mag;
        s   = 1'b0;
        if (force_sat || (mag > lim))
        begin
            m = lim;
            s = 1'b1;
        end
        return {s, neg ? 32'(34'd0 - m) : m[31:0]};
    endfunction

    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] vld_next;
    logic [PIPE_DEPTH-1:0] adv;

    prod_t     a_reg, a_next;
    sum_t      b_reg, b_next;
    mag_t      c_reg, c_next;
    stage_t    it_reg [ITER_COUNT+1];
    stage_t    it_next [ITER_COUNT+1];
    out_item_t o_reg, o_next;

    // stage moves when empty or when the next one moves
    assign adv[PIPE_DEPTH-1] = !vld_reg[PIPE_DEPTH-1] || !rsp_stall;
    for (genvar i = 0; i < PIPE_DEPTH - 1; i++)
    begin : g_adv
        assign adv[i] = !vld_reg[i] || adv[i+1];
    end

    assign req_stall = !adv[0];
    assign rsp_valid = vld_reg[PIPE_DEPTH-1];
    assign rsp       = o_reg;

    always_comb
    begin
        vld_next[0] = adv[0] ? req_valid : vld_reg[0];
        for (int i = 1; i < PIPE_DEPTH; i++)
        begin
            vld_next[i] = adv[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // products, add/sub, equality
    always_comb
    begin
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [32:0] sr;
        logic signed [32:0] si;
        logic [32:0]        rr;
        logic [32:0]        ri;
        x  = (req.action == ACT_MAG) ? req.a_re : req.b_re;
        y  = (req.action == ACT_MAG) ? req.a_im : req.b_im;
        sr = (req.action == ACT_SUB) ? 33'(req.a_re) - 33'(req.b_re)
                                     : 33'(req.a_re) + 33'(req.b_re);
        si = (req.action == ACT_SUB) ? 33'(req.a_im) - 33'(req.b_im)
                                     : 33'(req.a_im) + 33'(req.b_im);
        rr = sat_signed(65'(sr));
        ri = sat_signed(65'(si));
        a_next.cmn.action   = req.action;
        a_next.cmn.fix_re   = rr[31:0];
        a_next.cmn.fix_im   = ri[31:0];
        a_next.cmn.fix_sat  = rr[32] | ri[32];
        a_next.cmn.is_equal = (req.action == ACT_EQ) && (req.a_re == req.b_re)
                              && (req.a_im == req.b_im);
        a_next.p0 = req.a_re * req.b_re;
        a_next.p1 = req.a_im * req.b_im;
        a_next.p2 = req.a_re * req.b_im;
        a_next.p3 = req.a_im * req.b_re;
        a_next.p4 = x * x;
        a_next.p5 = y * y;
    end

    // cross sums and denominator (or sum of squares of a)
    always_comb
    begin
        b_next.cmn = a_reg.cmn;
        if (a_reg.cmn.action == ACT_MUL)
        begin
            b_next.sre = 65'(a_reg.p0) - 65'(a_reg.p1);
            b_next.sim = 65'(a_reg.p2) + 65'(a_reg.p3);
        end
        else
        begin
            b_next.sre = 65'(a_reg.p0) + 65'(a_reg.p1);
            b_next.sim = 65'(a_reg.p3) - 65'(a_reg.p2);
        end
        b_next.den = $unsigned(a_reg.p4) + $unsigned(a_reg.p5);
    end

    // product truncation, dividend magnitudes
    always_comb
    begin
        logic [32:0] mr;
        logic [32:0] mi;
        mr = sat_signed(b_reg.sre >>> FRAC_BITS);
        mi = sat_signed(b_reg.sim >>> FRAC_BITS);
        c_next.cmn = b_reg.cmn;
        if (b_reg.cmn.action == ACT_MUL)
        begin
            c_next.cmn.fix_re  = mr[31:0];
            c_next.cmn.fix_im  = mi[31:0];
            c_next.cmn.fix_sat = mr[32] | mi[32];
        end
        c_next.neg_re = b_reg.sre[64];
        c_next.neg_im = b_reg.sim[64];
        c_next.mag_re = b_reg.sre[64] ? 64'(-b_reg.sre) : b_reg.sre[63:0];
        c_next.mag_im = b_reg.sim[64] ? 64'(-b_reg.sim) : b_reg.sim[63:0];
        c_next.den    = b_reg.den;
    end

    // divider set-up: top of the scaled dividend is the first partial remainder
    always_comb
    begin
        logic [96:0] nre;
        logic [96:0] nim;
        nre = {33'd0, c_reg.mag_re} << FRAC_BITS;
        nim = {33'd0, c_reg.mag_im} << FRAC_BITS;
        it_next[0].cmn      = c_reg.cmn;
        it_next[0].neg_re   = c_reg.neg_re;
        it_next[0].neg_im   = c_reg.neg_im;
        it_next[0].r_re     = nre[96:33];
        it_next[0].r_im     = nim[96:33];
        it_next[0].n_re     = nre[32:0];
        it_next[0].n_im     = nim[32:0];
        // quotient would need more than 33 bits
        it_next[0].ovf_re   = nre[96:33] >= c_reg.den;
        it_next[0].ovf_im   = nim[96:33] >= c_reg.den;
        it_next[0].den_zero = c_reg.den == 64'd0;
        it_next[0].den      = c_reg.den;
        it_next[0].q_re     = '0;
        it_next[0].q_im     = '0;
        it_next[0].sq_src   = {2'b00, c_reg.den};
        it_next[0].sq_rem   = '0;
        it_next[0].sq_root  = '0;
    end

    for (genvar k = 0; k < ITER_COUNT; k++)
    begin : g_iter
        always_comb
        begin
            logic [64:0] tre;
            logic [64:0] tim;
            logic [34:0] rs;
            logic [34:0] tr;
            it_next[k+1] = it_reg[k];
            tre = {it_reg[k].r_re, it_reg[k].n_re[32]};
            tim = {it_reg[k].r_im, it_reg[k].n_im[32]};
            if (tre >= {1'b0, it_reg[k].den})
            begin
                it_next[k+1].r_re = 64'(tre - {1'b0, it_reg[k].den});
                it_next[k+1].q_re = {it_reg[k].q_re[31:0], 1'b1};
            end
            else
            begin
                it_next[k+1].r_re = tre[63:0];
                it_next[k+1].q_re = {it_reg[k].q_re[31:0], 1'b0};
            end
            if (tim >= {1'b0, it_reg[k].den})
            begin
                it_next[k+1].r_im = 64'(tim - {1'b0, it_reg[k].den});
                it_next[k+1].q_im = {it_reg[k].q_im[31:0], 1'b1};
            end
            else
            begin
                it_next[k+1].r_im = tim[63:0];
                it_next[k+1].q_im = {it_reg[k].q_im[31:0], 1'b0};
            end
            it_next[k+1].n_re = {it_reg[k].n_re[31:0], 1'b0};
            it_next[k+1].n_im = {it_reg[k].n_im[31:0], 1'b0};
            // square root, two radicand bits per step
            rs = {it_reg[k].sq_rem, it_reg[k].sq_src[65:64]};
            tr = {it_reg[k].sq_root, 2'b01};
            if (rs >= tr)
            begin
                it_next[k+1].sq_rem  = 33'(rs - tr);
                it_next[k+1].sq_root = {it_reg[k].sq_root[31:0], 1'b1};
            end
            else
            begin
                it_next[k+1].sq_rem  = rs[32:0];
                it_next[k+1].sq_root = {it_reg[k].sq_root[31:0], 1'b0};
            end
            it_next[k+1].sq_src = {it_reg[k].sq_src[63:0], 2'b00};
        end
    end

    // floor rounding, saturation, result select
    always_comb
    begin
        stage_t      s;
        logic [33:0] qre;
        logic [33:0] qim;
        logic [32:0] dre;
        logic [32:0] dim;
        logic [32:0] mg;
        logic        sat;
        logic        dz;
        s   = it_reg[ITER_COUNT];
        qre = {1'b0, s.q_re} + 34'(s.neg_re && (s.r_re != 64'd0));
        qim = {1'b0, s.q_im} + 34'(s.neg_im && (s.r_im != 64'd0));
        dre = sat_mag(s.neg_re, qre, s.ovf_re);
        dim = sat_mag(s.neg_im, qim, s.ovf_im);
        mg  = sat_mag(1'b0, {1'b0, s.sq_root}, 1'b0);
        o_next.res_re   = '0;
        o_next.res_im   = '0;
        o_next.is_equal = 1'b0;
        sat = 1'b0;
        dz  = 1'b0;
        unique case (s.cmn.action)
            ACT_ADD, ACT_SUB, ACT_MUL:
            begin
                o_next.res_re = s.cmn.fix_re;
                o_next.res_im = s.cmn.fix_im;
                sat           = s.cmn.fix_sat;
            end
            ACT_DIV:
            begin
                if (s.den_zero)
                begin
                    dz = 1'b1;
                end
                else
                begin
                    o_next.res_re = dre[31:0];
                    o_next.res_im = dim[31:0];
                    sat           = dre[32] | dim[32];
                end
            end
            ACT_MAG:
            begin
                o_next.res_re = mg[31:0];
                sat           = mg[32];
            end
            ACT_EQ:
            begin
                o_next.is_equal = s.cmn.is_equal;
            end
            default:
            begin
            end
        endcase
        o_next.status = sat ? ST_SAT : (dz ? ST_DIV_ZERO : ST_OK);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            a_reg <= a_next;
        end
        if (adv[1])
        begin
            b_reg <= b_next;
        end
        if (adv[2])
        begin
            c_reg <= c_next;
        end
        if (adv[3])
        begin
            it_reg[0] <= it_next[0];
        end
        if (adv[PIPE_DEPTH-1])
        begin
            o_reg <= o_next;
        end
    end

    for (genvar k = 0; k < ITER_COUNT; k++)
    begin : g_iter_reg
        always_ff @(posedge clk)
        begin
            if (adv[k+4])
            begin
                it_reg[k+1] <= it_next[k+1];
            end
        end
    end

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (vld_reg[PIPE_DEPTH-1] && rsp_stall))
        else $error("request stalled while the pipe could move");

    a_div_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == ST_DIV_ZERO)) |-> ((rsp.res_re == 32'sd0)
        && (rsp.res_im == 32'sd0) && !rsp.is_equal))
        else $error("divide by zero with non-zero result");

    a_equal_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.is_equal) |-> ((rsp.status == ST_OK)
        && (rsp.res_re == 32'sd0) && (rsp.res_im == 32'sd0)))
        else $error("equality result carries data or status");

    a_rsp_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled response changed");
`endif

endmodule
